// ===== hdl/utf8sc_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 stream checker.
`default_nettype none
package utf8sc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned LIMIT_WIDTH     = 32;
  localparam int unsigned OUT_WIDTH       = 32;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = '1;

  // Narrowed range that applies to the first continuation byte.
  typedef enum logic [2:0] {
    CLS_PLAIN = 3'd0,
    CLS_E0    = 3'd1,
    CLS_ED    = 3'd2,
    CLS_F0    = 3'd3,
    CLS_F4    = 3'd4
  } cont_class_t;

  typedef struct packed {
    logic in_plain;  // 80..BF
    logic in_e0;     // A0..BF
    logic in_ed;     // 80..9F
    logic in_f0;     // 90..BF
    logic in_f4;     // 80..8F
  } cont_fit_t;

  typedef struct packed {
    logic [2:0]  lead_len;    // 0 for a bad lead, else 1..4
    cont_class_t lead_class;
    cont_fit_t   fit;
    logic        last;
  } byte_info_t;

  function automatic logic [2:0] seq_length(input logic [7:0] b);
    logic [2:0] n;
    if (b < 8'h80)      n = 3'd1;
    else if (b < 8'hC2) n = 3'd0;
    else if (b < 8'hE0) n = 3'd2;
    else if (b < 8'hF0) n = 3'd3;
    else if (b < 8'hF5) n = 3'd4;
    else                n = 3'd0;
    return n;
  endfunction

  function automatic cont_class_t class_of(input logic [7:0] b);
    cont_class_t c;
    case (b)
      8'hE0:   c = CLS_E0;
      8'hED:   c = CLS_ED;
      8'hF0:   c = CLS_F0;
      8'hF4:   c = CLS_F4;
      default: c = CLS_PLAIN;
    endcase
    return c;
  endfunction

  function automatic logic cont_fits(input cont_fit_t f, input cont_class_t c);
    logic ok;
    case (c)
      CLS_E0:  ok = f.in_e0;
      CLS_ED:  ok = f.in_ed;
      CLS_F0:  ok = f.in_f0;
      CLS_F4:  ok = f.in_f4;
      default: ok = f.in_plain;
    endcase
    return ok;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/utf8sc_front.sv =====
// Front end: decodes each incoming byte into its lead and continuation classes.
`default_nettype none
module utf8sc_front (
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_text_byte,
  input  wire logic                  in_final_byte,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output utf8sc_pkg::byte_info_t     push_item
);

  always_comb begin
    push_item.lead_len     = utf8sc_pkg::seq_length(in_text_byte);
    push_item.lead_class   = utf8sc_pkg::class_of(in_text_byte);
    push_item.fit.in_plain = (in_text_byte >= 8'h80) && (in_text_byte <= 8'hBF);
    push_item.fit.in_e0    = (in_text_byte >= 8'hA0) && (in_text_byte <= 8'hBF);
    push_item.fit.in_ed    = (in_text_byte >= 8'h80) && (in_text_byte <= 8'h9F);
    push_item.fit.in_f0    = (in_text_byte >= 8'h90) && (in_text_byte <= 8'hBF);
    push_item.fit.in_f4    = (in_text_byte >= 8'h80) && (in_text_byte <= 8'h8F);
    push_item.last         = in_final_byte;
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule
`default_nettype wire

// ===== hdl/utf8sc_queue.sv =====
// Short queue of decoded bytes between the front end and the back end.
`default_nettype none
module utf8sc_queue #(
  parameter int unsigned DEPTH = utf8sc_pkg::QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push_valid,
  output logic                        push_ready,
  input  wire utf8sc_pkg::byte_info_t push_item,
  output logic                        pop_valid,
  input  wire logic                   pop_ready,
  output utf8sc_pkg::byte_info_t      pop_item,
  output logic [$clog2(DEPTH+1)-1:0]  fill
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  utf8sc_pkg::byte_info_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];
  assign fill       = count_r;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/utf8sc_back.sv =====
// Back end: validation state, code point count, truncation walker and result register.
`default_nettype none
module utf8sc_back #(
  parameter int unsigned COUNT_WIDTH = utf8sc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [utf8sc_pkg::LIMIT_WIDTH-1:0]   byte_limit,
  input  wire logic                                 item_valid,
  output logic                                      item_ready,
  input  wire utf8sc_pkg::byte_info_t               item,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_text_valid,
  output logic [utf8sc_pkg::OUT_WIDTH-1:0]          out_code_points,
  output logic [utf8sc_pkg::OUT_WIDTH-1:0]          out_cut_length
);

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned CMP_W = (CW > utf8sc_pkg::LIMIT_WIDTH) ? CW : utf8sc_pkg::LIMIT_WIDTH;
  localparam int unsigned OW    = utf8sc_pkg::OUT_WIDTH;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [2:0] n);
    logic [CW:0] s;
    s = {1'b0, a} + {{(CW-2){1'b0}}, n};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  logic                    still_valid_r, still_valid_nxt;
  logic [1:0]              pending_r, pending_nxt;
  utf8sc_pkg::cont_class_t fcc_r, fcc_nxt;
  logic                    at_first_r, at_first_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic [CW-1:0]           pc_r, pc_nxt;
  logic [CW-1:0]           nse_r, nse_nxt;
  logic [CW-1:0]           cc_r, cc_nxt;
  logic                    frozen_r, frozen_nxt;

  logic                    out_valid_r, out_text_valid_r;
  logic [OW-1:0]           out_code_points_r, out_cut_length_r;

  logic                    take;
  logic                    fits;
  logic [2:0]              step_len;
  logic [CW-1:0]           step_end, len_v;
  logic                    final_valid;
  logic [OW-1:0]           cut_v;

  // A final byte may only leave once the result register is free.
  assign item_ready = !item.last || !out_valid_r || out_ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    still_valid_nxt = still_valid_r;
    pending_nxt     = pending_r;
    fcc_nxt         = fcc_r;
    at_first_nxt    = at_first_r;
    pc_nxt          = pc_r;
    nse_nxt         = nse_r;
    cc_nxt          = cc_r;
    frozen_nxt      = frozen_r;
    fits            = 1'b0;

    if (pending_r == 2'd0) begin
      case (item.lead_len)
        3'd0: still_valid_nxt = 1'b0;
        3'd1: pc_nxt = sat_add(pc_r, 3'd1);
        default: begin
          pending_nxt  = 2'(item.lead_len - 3'd1);
          fcc_nxt      = item.lead_class;
          at_first_nxt = 1'b1;
        end
      endcase
    end else begin
      fits = utf8sc_pkg::cont_fits(item.fit, at_first_r ? fcc_r : utf8sc_pkg::CLS_PLAIN);
      if (!fits) begin
        still_valid_nxt = 1'b0;
        pending_nxt     = 2'd0;
      end else begin
        pending_nxt = pending_r - 2'd1;
        if (pending_r == 2'd1) begin
          pc_nxt = sat_add(pc_r, 3'd1);
        end
      end
      at_first_nxt = 1'b0;
    end

    // The walker steps by declared lengths; a bad lead counts as one byte.
    step_len = (item.lead_len == 3'd0) ? 3'd1 : item.lead_len;
    step_end = sat_add(pos_r, step_len);
    if (!frozen_r && (pos_r == cc_r)) begin
      if (CMP_W'(step_end) > CMP_W'(byte_limit)) begin
        frozen_nxt = 1'b1;
      end else begin
        nse_nxt = step_end;
      end
    end
    len_v = sat_add(pos_r, 3'd1);
    if (!frozen_nxt && (len_v == nse_nxt)) begin
      cc_nxt = nse_nxt;
    end
    pos_nxt = len_v;

    final_valid = still_valid_nxt && (pending_nxt == 2'd0);
    cut_v = (CMP_W'(len_v) <= CMP_W'(byte_limit)) ? OW'(len_v) : OW'(cc_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      still_valid_r <= 1'b1;
      pending_r     <= 2'd0;
      fcc_r         <= utf8sc_pkg::CLS_PLAIN;
      at_first_r    <= 1'b0;
      pos_r         <= '0;
      pc_r          <= '0;
      nse_r         <= '0;
      cc_r          <= '0;
      frozen_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !(take && item.last)) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        if (item.last) begin
          still_valid_r <= 1'b1;
          pending_r     <= 2'd0;
          fcc_r         <= utf8sc_pkg::CLS_PLAIN;
          at_first_r    <= 1'b0;
          pos_r         <= '0;
          pc_r          <= '0;
          nse_r         <= '0;
          cc_r          <= '0;
          frozen_r      <= 1'b0;
          out_valid_r   <= 1'b1;
        end else begin
          still_valid_r <= still_valid_nxt;
          pending_r     <= pending_nxt;
          fcc_r         <= fcc_nxt;
          at_first_r    <= at_first_nxt;
          pos_r         <= pos_nxt;
          pc_r          <= pc_nxt;
          nse_r         <= nse_nxt;
          cc_r          <= cc_nxt;
          frozen_r      <= frozen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last) begin
      out_text_valid_r  <= final_valid;
      out_code_points_r <= final_valid ? OW'(pc_nxt) : '0;
      out_cut_length_r  <= cut_v;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_text_valid  = out_text_valid_r;
  assign out_code_points = out_code_points_r;
  assign out_cut_length  = out_cut_length_r;

endmodule
`default_nettype wire

// ===== hdl/utf8_stream_checker.sv =====
// Top level of the UTF-8 stream checker: config register, front end, queue and back end.
//
// The checker takes one text byte per cycle while in_ready is high and, on the byte flagged
// final, returns one result: whether the text is well-formed UTF-8, its code point count
// (zero when invalid) and the longest prefix of whole sequences that fits in byte_limit.
// Bytes are decoded in the front end and pass through a two-entry queue to the back end,
// whose single state update per byte sets the rate at one byte per clock while no final byte
// is stalled. in_ready drops only when the queue is full, which happens while a finished
// result waits in the output register and another final byte is behind it. byte_limit is
// to be written through the cfg port, always ready, only between texts; nothing enforces it.
`default_nettype none
module utf8_stream_checker #(
  parameter int unsigned COUNT_WIDTH = utf8sc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [utf8sc_pkg::LIMIT_WIDTH-1:0]   cfg_byte_limit,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [7:0]                           in_text_byte,
  input  wire logic                                 in_final_byte,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_text_valid,
  output logic [utf8sc_pkg::OUT_WIDTH-1:0]          out_code_points,
  output logic [utf8sc_pkg::OUT_WIDTH-1:0]          out_cut_length
);

  localparam int unsigned DEPTH = utf8sc_pkg::QUEUE_DEPTH;

  logic [utf8sc_pkg::LIMIT_WIDTH-1:0] byte_limit_r;
  logic                               push_valid, push_ready;
  utf8sc_pkg::byte_info_t             push_item, pop_item;
  logic                               pop_valid, pop_ready;
  logic [$clog2(DEPTH+1)-1:0]         fill;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_limit_r <= utf8sc_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      byte_limit_r <= cfg_byte_limit;
    end
  end

  utf8sc_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  utf8sc_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .fill       (fill)
  );

  utf8sc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_limit      (byte_limit_r),
    .item_valid      (pop_valid),
    .item_ready      (pop_ready),
    .item            (pop_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_text_valid  (out_text_valid),
    .out_code_points (out_code_points),
    .out_cut_length  (out_cut_length)
  );

  // A final byte must never be taken while an unread result is still held.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready && pop_item.last) |-> (!out_valid || out_ready))
    else $error("final transfer would overwrite a pending result");

  // An invalid text reports a zero code point count.
  a_invalid_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_text_valid) |-> (out_code_points == '0))
    else $error("invalid text reported a nonzero code point count");

  // The cut never exceeds the limit it was computed against.
  a_cut_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_cut_length <= byte_limit_r))
    else $error("cut length exceeds byte limit");

  // The queue fill level stays within its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= ($clog2(DEPTH+1))'(DEPTH))
    else $error("queue fill exceeds depth");

endmodule
`default_nettype wire
